// ===== src/lcc_pkg.sv =====
// Package: sizes, command/status structs and controller state for the LRU cache.
`timescale 1ns / 1ps
package lcc_pkg;
  localparam int NumLines  = 8;
  localparam int LineBytes = 4;
  localparam int MemBytes  = 16384;
  localparam int LineW     = $clog2(NumLines);
  localparam int OffW      = $clog2(LineBytes);
  localparam int AddrW     = $clog2(MemBytes);
  localparam int TagW      = AddrW - OffW;
  localparam int DataW     = LineBytes > 1 ? $clog2(NumLines * LineBytes) : 1;
  localparam int CostW     = 10;

  localparam logic [1:0] CfgCacheRd = 2'd0;
  localparam logic [1:0] CfgCacheWr = 2'd1;
  localparam logic [1:0] CfgMemRd   = 2'd2;
  localparam logic [1:0] CfgMemWr   = 2'd3;

  typedef enum logic [2:0] {
    StIdle, StLookup, StWback, StFill, StFillLast, StRead, StDone
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request, start lookup
    logic resolve;    // register hit line / victim
    logic wb_step;    // copy one line byte to memory
    logic fill_rd;    // issue memory read for fill byte
    logic fill_wr;    // store returned fill byte into line
    logic rd_issue;   // read addressed byte / do write action
    logic finish;     // present result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_write;
    logic hit;
    logic victim_dirty;
    logic last_byte;
  } sts_t;
endpackage

// ===== src/lcc_datapath.sv =====
// Datapath: line tags, state bits, recency ranks, line data and backing memory.
`timescale 1ns / 1ps
module lcc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcc_pkg::cmd_t         cmd_i,
  output lcc_pkg::sts_t         sts_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  req_type_i,
  input  logic [lcc_pkg::AddrW-1:0] byte_addr_i,
  input  logic [7:0]            write_byte_i,
  output logic [7:0]            read_byte_o,
  output logic                  was_hit_o,
  output logic [lcc_pkg::CostW-1:0] cost_ticks_o
);
  localparam int NL = lcc_pkg::NumLines;

  logic [7:0] crd_q, cwr_q, mrd_q, mwr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crd_q <= 8'd2; cwr_q <= 8'd4; mrd_q <= 8'd5; mwr_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcc_pkg::CfgCacheRd: crd_q <= cfg_data_i;
        lcc_pkg::CfgCacheWr: cwr_q <= cfg_data_i;
        lcc_pkg::CfgMemRd:   mrd_q <= cfg_data_i;
        lcc_pkg::CfgMemWr:   mwr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                       wr_q;
  logic [lcc_pkg::AddrW-1:0]  addr_q;
  logic [7:0]                 wbyte_q;
  logic [lcc_pkg::TagW-1:0]   tag_q [NL];
  logic [NL-1:0]              valid_q, dirty_q;
  logic [lcc_pkg::LineW-1:0]  rank_q [NL];
  logic [lcc_pkg::LineW-1:0]  ln_q;
  logic                       hit_q, vdirty_q;
  logic [lcc_pkg::OffW:0]     k_q;
  logic [lcc_pkg::TagW-1:0]   wb_tag_q;

  logic [lcc_pkg::TagW-1:0] req_tag;
  logic [lcc_pkg::OffW-1:0] req_off;
  assign req_tag = addr_q[lcc_pkg::AddrW-1:lcc_pkg::OffW];
  assign req_off = addr_q[lcc_pkg::OffW-1:0];

  // hit match and victim select: parallel compares over lines
  logic                      hit_c;
  logic [lcc_pkg::LineW-1:0] hit_ln, old_ln;
  always_comb begin
    hit_c = 1'b0;
    hit_ln = '0;
    old_ln = '0;
    for (int i = 0; i < NL; i++) begin
      if (valid_q[i] && tag_q[i] == req_tag && !hit_c) begin
        hit_c = 1'b1;
        hit_ln = lcc_pkg::LineW'(i);
      end
      // ranks are a permutation: exactly one line is oldest
      if (rank_q[i] == lcc_pkg::LineW'(NL - 1)) old_ln = lcc_pkg::LineW'(i);
    end
  end

  // memories
  logic [7:0] line_mem [NL * lcc_pkg::LineBytes];
  logic [7:0] back_mem [lcc_pkg::MemBytes];
  logic [7:0] line_rd_q, back_rd_q;
  logic [lcc_pkg::OffW-1:0] k_off;
  assign k_off = k_q[lcc_pkg::OffW-1:0];

  logic [lcc_pkg::DataW-1:0] line_ra, line_wa;
  logic                      line_we;
  logic [7:0]                line_wd;
  logic [lcc_pkg::AddrW-1:0] back_ra, back_wa;
  logic                      back_we;
  logic [7:0]                back_wd;

  always_comb begin
    line_ra = lcc_pkg::DataW'({ln_q, req_off});
    line_we = 1'b0;
    line_wa = lcc_pkg::DataW'({ln_q, k_off});
    line_wd = back_rd_q;
    back_ra = {req_tag, k_off};
    back_we = 1'b0;
    back_wa = {wb_tag_q, k_off};
    back_wd = line_rd_q;
    if (cmd_i.wb_step || (cmd_i.resolve && !hit_c && !wr_q)) begin
      line_ra = lcc_pkg::DataW'({(cmd_i.resolve ? old_ln : ln_q),
                                 (cmd_i.resolve ? lcc_pkg::OffW'(0)
                                                : lcc_pkg::OffW'(k_off + 1'b1))});
    end
    if (cmd_i.wb_step) back_we = 1'b1;
    if (cmd_i.fill_wr) line_we = 1'b1;
    if (cmd_i.rd_issue && wr_q) begin
      if (hit_q) begin
        line_we = 1'b1;
        line_wa = lcc_pkg::DataW'({ln_q, req_off});
        line_wd = wbyte_q;
      end else begin
        back_we = 1'b1;
        back_wa = addr_q;
        back_wd = wbyte_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_wa] <= line_wd;
    line_rd_q <= line_mem[line_ra];
  end
  always_ff @(posedge clk_i) begin
    if (back_we) back_mem[back_wa] <= back_wd;
    if (cmd_i.fill_rd) back_rd_q <= back_mem[back_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      wr_q <= req_type_i; addr_q <= byte_addr_i; wbyte_q <= write_byte_i;
    end
    if (cmd_i.resolve) begin
      hit_q <= hit_c;
      ln_q <= hit_c ? hit_ln : old_ln;
      vdirty_q <= valid_q[old_ln] && dirty_q[old_ln];
      wb_tag_q <= tag_q[old_ln];
    end
  end

  logic k_clr;
  assign k_clr = cmd_i.resolve || (cmd_i.wb_step && sts_o.last_byte);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_q <= '0;
    else if (k_clr) k_q <= '0;
    else if (cmd_i.wb_step || cmd_i.fill_wr) k_q <= k_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int i = 0; i < NL; i++) begin
        tag_q[i] <= '0;
        rank_q[i] <= lcc_pkg::LineW'(i);
      end
    end else if (cmd_i.rd_issue) begin
      if (wr_q) begin
        if (hit_q) dirty_q[ln_q] <= 1'b1;
      end else begin
        for (int i = 0; i < NL; i++)
          if (rank_q[i] < rank_q[ln_q]) rank_q[i] <= rank_q[i] + 1'b1;
        rank_q[ln_q] <= '0;
        if (!hit_q) begin
          tag_q[ln_q] <= req_tag;
          valid_q[ln_q] <= 1'b1;
          dirty_q[ln_q] <= 1'b0;
        end
      end
    end
  end

  // lookup outcome passes straight through while resolving so the controller can branch
  assign sts_o.is_write     = wr_q;
  assign sts_o.hit          = cmd_i.resolve ? hit_c : hit_q;
  assign sts_o.victim_dirty = cmd_i.resolve ? (valid_q[old_ln] && dirty_q[old_ln])
                                            : vdirty_q;
  assign sts_o.last_byte    = k_q == (lcc_pkg::OffW + 1)'(lcc_pkg::LineBytes - 1);

  // result register
  logic [lcc_pkg::CostW-1:0] cost_c;
  always_comb begin
    if (wr_q) cost_c = hit_q ? lcc_pkg::CostW'(cwr_q) : lcc_pkg::CostW'(mwr_q);
    else cost_c = lcc_pkg::CostW'(crd_q)
                + (hit_q ? '0 : lcc_pkg::CostW'(mrd_q)
                   + (vdirty_q ? lcc_pkg::CostW'(mwr_q) : '0));
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      read_byte_o  <= wr_q ? 8'd0 : line_rd_q;
      was_hit_o    <= hit_q;
      cost_ticks_o <= cost_c;
    end
  end

  function automatic logic [NL-1:0] rank_zero_vec();
    logic [NL-1:0] v;
    for (int i = 0; i < NL; i++) v[i] = rank_q[i] == '0;
    return v;
  endfunction

  rank_perm_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> $onehot(rank_zero_vec()))
    else $error("recency ranks lost rank zero");
  wb_only_dirty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb_step |-> vdirty_q && !hit_q && !wr_q)
    else $error("write-back of clean or hit line");
  fill_on_miss_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_wr |-> !hit_q && !wr_q)
    else $error("fill on hit or write");
endmodule

// ===== src/lcc_ctrl.sv =====
// Controller: sequences lookup, write-back, fill and result for one request.
`timescale 1ns / 1ps
module lcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  input  lcc_pkg::sts_t sts_i,
  output lcc_pkg::cmd_t cmd_o
);
  lcc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= lcc_pkg::StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lcc_pkg::StIdle:   if (start) state_d = lcc_pkg::StLookup;
      lcc_pkg::StLookup: begin
        if (sts_i.is_write || sts_i.hit) state_d = lcc_pkg::StRead;
        else if (sts_i.victim_dirty) state_d = lcc_pkg::StWback;
        else state_d = lcc_pkg::StFill;
      end
      lcc_pkg::StWback:  if (sts_i.last_byte) state_d = lcc_pkg::StFill;
      lcc_pkg::StFill:   state_d = lcc_pkg::StFillLast;
      lcc_pkg::StFillLast: state_d = sts_i.last_byte ? lcc_pkg::StRead : lcc_pkg::StFill;
      lcc_pkg::StRead:   state_d = lcc_pkg::StDone;
      lcc_pkg::StDone:   state_d = lcc_pkg::StIdle;
      default:           state_d = lcc_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.capture  = state_q == lcc_pkg::StIdle && start;
    cmd_o.resolve  = state_q == lcc_pkg::StLookup;
    cmd_o.wb_step  = state_q == lcc_pkg::StWback;
    cmd_o.fill_rd  = state_q == lcc_pkg::StFill;
    cmd_o.fill_wr  = state_q == lcc_pkg::StFillLast;
    cmd_o.rd_issue = state_q == lcc_pkg::StRead;
    cmd_o.finish   = state_q == lcc_pkg::StDone;
  end

  assign busy   = state_q != lcc_pkg::StIdle;
  assign done_o = state_q == lcc_pkg::StDone;

  one_cmd_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.resolve, cmd_o.wb_step, cmd_o.fill_rd, cmd_o.fill_wr,
              cmd_o.rd_issue, cmd_o.finish}))
    else $error("overlapping commands");
  accept_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.resolve)
    else $error("accepted request skipped lookup");
  finish_after_read_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> $past(cmd_o.rd_issue))
    else $error("result without read step");
endmodule

// ===== src/lru_cache_controller.sv =====
// Top level: fully associative LRU byte cache with internal backing memory.
// Steps: a hit or any write goes accept, lookup, access, result before the
// result strobe; a read miss adds a memory read and a fill write per line byte
// for the fill, plus a write-back step per byte for a dirty victim, through the
// one-byte-per-cycle memory ports. One request at a time; busy is high until the strobe, which cannot stall.
// Reset clears valid and dirty, sets ranks to line order and ticks to defaults.
`timescale 1ns / 1ps
module lru_cache_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          req_type_i,
  input  logic [lcc_pkg::AddrW-1:0]     byte_addr_i,
  input  logic [7:0]                    write_byte_i,
  output logic                          result_valid_o,
  output logic [7:0]                    read_byte_o,
  output logic                          was_hit_o,
  output logic [lcc_pkg::CostW-1:0]     cost_ticks_o
);
  lcc_pkg::cmd_t cmd;
  lcc_pkg::sts_t sts;
  logic          done;
  logic          fin_q;

  lcc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .done_o(done), .sts_i(sts), .cmd_o(cmd)
  );

  lcc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .byte_addr_i, .write_byte_i,
    .read_byte_o, .was_hit_o, .cost_ticks_o
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_q <= 1'b0;
    else fin_q <= done;
  end
  assign result_valid_o = fin_q;
endmodule

// ===== tb/sv/lcc_checker.sv =====
// Checker for the LRU cache: watches config, request and result channels and predicts results.
`timescale 1ns / 1ps
module lcc_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      req_type_i,
  input  logic [lcc_pkg::AddrW-1:0] byte_addr_i,
  input  logic [7:0]                write_byte_i,
  input  logic                      result_valid_o,
  input  logic [7:0]                read_byte_o,
  input  logic                      was_hit_o,
  input  logic [lcc_pkg::CostW-1:0] cost_ticks_o,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        hits_o
);
  import lcc_pkg::*;

  typedef struct packed {
    logic [7:0]       rbyte;
    logic             hit;
    logic [CostW-1:0] cost;
  } access_t;

  access_t          expected_q[$];
  logic [7:0]       tick_cache_rd, tick_cache_wr, tick_mem_rd, tick_mem_wr;
  logic [TagW-1:0]  line_tag[NumLines];
  logic             line_valid[NumLines];
  logic             line_dirty[NumLines];
  logic [7:0]       line_bytes[NumLines][LineBytes];
  int               line_age[NumLines];
  logic [7:0]       mem_model[MemBytes];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count_o++;
  endtask

  task automatic promote(input int ln);
    int r;
    r = line_age[ln];
    for (int i = 0; i < NumLines; i++)
      if (line_age[i] < r) line_age[i]++;
    line_age[ln] = 0;
  endtask

  function automatic int find_victim();
    int best;
    best = 0;
    for (int i = 1; i < NumLines; i++)
      if (line_age[i] > line_age[best]) best = i;
    return best;
  endfunction

  task automatic predict_access(input logic is_wr, input logic [AddrW-1:0] addr,
                                input logic [7:0] wb, output access_t res);
    logic [TagW-1:0] tag;
    int              off, ln;
    logic [CostW-1:0] cost;
    tag  = addr[AddrW-1:OffW];
    off  = addr[OffW-1:0];
    ln   = -1;
    cost = '0;
    res  = '0;
    for (int i = 0; i < NumLines; i++)
      if (ln < 0 && line_valid[i] && line_tag[i] == tag) ln = i;
    if (is_wr) begin
      if (ln >= 0) begin
        res.hit = 1'b1;
        line_bytes[ln][off] = wb;
        line_dirty[ln] = 1'b1;
        cost = tick_cache_wr;
      end else begin
        mem_model[addr] = wb;
        cost = tick_mem_wr;
      end
    end else begin
      if (ln >= 0) begin
        res.hit = 1'b1;
      end else begin
        ln = find_victim();
        if (line_valid[ln] && line_dirty[ln]) begin
          for (int k = 0; k < LineBytes; k++)
            mem_model[(int'(line_tag[ln]) * LineBytes + k) % MemBytes] = line_bytes[ln][k];
          cost += tick_mem_wr;
        end
        for (int k = 0; k < LineBytes; k++)
          line_bytes[ln][k] = mem_model[(int'(tag) * LineBytes + k) % MemBytes];
        line_tag[ln]   = tag;
        line_valid[ln] = 1'b1;
        line_dirty[ln] = 1'b0;
        cost += tick_mem_rd;
      end
      promote(ln);
      res.rbyte = line_bytes[ln][off];
      cost += tick_cache_rd;
    end
    res.cost = cost;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_t exp_r;
    if (!rst_ni) begin
      expected_q.delete();
      tick_cache_rd = 8'd2;
      tick_cache_wr = 8'd4;
      tick_mem_rd   = 8'd5;
      tick_mem_wr   = 8'd10;
      for (int i = 0; i < NumLines; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_age[i]   = i;
        for (int k = 0; k < LineBytes; k++) line_bytes[i][k] = '0;
      end
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCacheRd: tick_cache_rd = cfg_data_i;
          CfgCacheWr: tick_cache_wr = cfg_data_i;
          CfgMemRd:   tick_mem_rd   = cfg_data_i;
          CfgMemWr:   tick_mem_wr   = cfg_data_i;
          default: ;
        endcase
      end
      // result strobe is checked before this edge's transfer is predicted
      if (result_valid_o) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.hit) hits_o++;
          if (read_byte_o !== exp_r.rbyte) report("read_byte", read_byte_o, exp_r.rbyte);
          if (was_hit_o !== exp_r.hit) report("was_hit", was_hit_o, exp_r.hit);
          if (cost_ticks_o !== exp_r.cost) report("cost_ticks", cost_ticks_o, exp_r.cost);
        end
      end
      if (start && !busy) begin
        predict_access(req_type_i, byte_addr_i, write_byte_i, exp_r);
        expected_q.push_back(exp_r);
      end
      pending_o = expected_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    hits_o       = 0;
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives requests and config writes into the LRU cache and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import lcc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PoolSize   = 12;

  logic             clk_i, rst_ni, start, busy, cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [7:0]       cfg_data_i, write_byte_i, read_byte_o;
  logic             req_type_i, result_valid_o, was_hit_o;
  logic [AddrW-1:0] byte_addr_i;
  logic [CostW-1:0] cost_ticks_o;
  int               fail_count, pending, hits, cycles, items_sent, idle_pct;
  logic [TagW-1:0]  tag_pool[PoolSize];
  bit               mem_written[MemBytes];

  lru_cache_controller u_top (.*);

  lcc_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .byte_addr_i, .write_byte_i, .result_valid_o, .read_byte_o,
    .was_hit_o, .cost_ticks_o, .fail_count_o(fail_count), .pending_o(pending),
    .hits_o(hits)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that completes the transfer
  task automatic send(input logic is_wr, input logic [AddrW-1:0] addr, input logic [7:0] wb);
    logic took;
    start        <= 1'b1;
    req_type_i   <= is_wr;
    byte_addr_i  <= addr;
    write_byte_i <= wb;
    mem_written[addr] = mem_written[addr] | is_wr;
    items_sent++;
    do begin
      @(negedge clk_i);
      took = !busy;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_ticks(input logic [7:0] crd, cwr, mrd, mwr);
    logic [7:0] vals[4];
    vals = '{crd, cwr, mrd, mwr};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a read of a line whose memory bytes are not all written turns into a write
  task automatic random_request();
    logic [TagW-1:0]  tag;
    logic [AddrW-1:0] addr;
    logic             is_wr;
    int               hole;
    tag   = tag_pool[$urandom_range(PoolSize - 1)];
    addr  = {tag, OffW'($urandom_range(LineBytes - 1))};
    is_wr = ($urandom_range(99) < 35);
    hole  = -1;
    for (int k = LineBytes - 1; k >= 0; k--)
      if (!mem_written[{tag, OffW'(k)}]) hole = k;
    if (!is_wr && hole >= 0) begin
      is_wr = 1'b1;
      addr  = {tag, OffW'(hole)};
    end
    send(is_wr, addr, 8'($urandom));
  endtask

  initial begin
    clk_i = 0; rst_ni = 0; start = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    req_type_i = 0; byte_addr_i = '0; write_byte_i = '0;
    cycles = 0; items_sent = 0; idle_pct = 0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) tag_pool[i] = TagW'($urandom);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: write lowest and highest memory lines, then miss, hit, write hit, write miss
    send(1'b1, 14'd0, 8'h00);
    send(1'b1, 14'd1, 8'hff);
    send(1'b1, 14'd2, 8'haa);
    send(1'b1, 14'd3, 8'h55);
    for (int k = 0; k < LineBytes; k++) send(1'b1, 14'(MemBytes - 1 - k), 8'(k * 85));
    send(1'b0, 14'd0, 8'hff);
    send(1'b0, 14'd3, 8'h00);
    send(1'b1, 14'd1, 8'h5a);
    send(1'b0, 14'd1, 8'h00);
    send(1'b0, 14'(MemBytes - 1), 8'h00);
    send(1'b1, 14'd30, 8'h81);
    send(1'b1, 14'(MemBytes - 2), 8'h7e);
    send(1'b0, 14'(MemBytes - 2), 8'h00);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_ticks(8'd255, 8'd255, 8'd255, 8'd255);
        1: set_ticks(8'd0, 8'd0, 8'd0, 8'd0);
        2: set_ticks(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: set_ticks(8'd2, 8'd4, 8'd5, 8'd10);
      endcase
      for (int i = 0; i < 275; i++) begin
        // idling modes rotate in stretches of 55 transfers
        case ((i / 55 + phase) % 4)
          0, 3:    idle_pct = 0;
          1:       idle_pct = 86;
          default: idle_pct = 38;
        endcase
        idle_gap();
        random_request();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d requests over 5 tick settings, %0d hits", items_sent, hits);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
